// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the clock top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hhmm_pkg.sv =====
// Types, constants and digit update functions of the HH:MM clock
package hhmm_pkg;

    // Minute length after reset, in one-second passes
    localparam logic [7:0] C_SPM_RESET = 8'd60;

    // Configuration register word index (held in paddr[2])
    localparam logic C_REG_SPM = 1'b0;

    // Digit limits
    localparam logic [3:0] C_UNITS_WRAP  = 4'd10;
    localparam logic [3:0] C_UNITS_TOP   = 4'd9;
    localparam logic [2:0] C_MTENS_WRAP  = 3'd6;
    localparam logic [2:0] C_MTENS_TOP   = 3'd5;
    localparam logic [3:0] C_HUNITS_LATE = 4'd3;
    localparam logic [1:0] C_HTENS_WRAP  = 2'd3;
    localparam logic [1:0] C_HTENS_TOP   = 2'd2;
    localparam logic [1:0] C_HTENS_EARLY = 2'd1;

    // Digit select codes
    typedef enum logic [1:0] {
        SEL_MIN_UNITS  = 2'd0,
        SEL_MIN_TENS   = 2'd1,
        SEL_HOUR_UNITS = 2'd2,
        SEL_HOUR_TENS  = 2'd3
    } t_digit_sel;

    // Time of day, minute units in the lowest bits
    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
    } t_time;

    // Advance by one minute, wrapping 23:59 to 00:00
    function automatic t_time f_advance(input t_time t);
        t_time r;
        r = t;
        if (t.hour_tens == C_HTENS_TOP && t.hour_units == C_HUNITS_LATE &&
            t.minute_tens == C_MTENS_TOP && t.minute_units >= C_UNITS_TOP) begin
            r = '0;
        end else if (t.minute_units >= C_UNITS_TOP) begin
            r.minute_units = '0;
            r.minute_tens  = t.minute_tens + 3'd1;
            if (r.minute_tens >= C_MTENS_WRAP) begin
                r.minute_tens = '0;
                r.hour_units  = t.hour_units + 4'd1;
                if (r.hour_units >= C_UNITS_WRAP) begin
                    r.hour_units = '0;
                    r.hour_tens  = t.hour_tens + 2'd1;
                    if (r.hour_tens >= C_HTENS_WRAP) begin
                        r.hour_tens = '0;
                    end
                end
            end
        end else begin
            r.minute_units = t.minute_units + 4'd1;
        end
        return r;
    endfunction

    // Increment the selected digit under the hour limits
    function automatic t_time f_increment(input t_time t, input t_digit_sel sel);
        t_time r;
        r = t;
        case (sel)
            SEL_MIN_UNITS: begin
                r.minute_units = t.minute_units + 4'd1;
                if (r.minute_units >= C_UNITS_WRAP) r.minute_units = '0;
            end
            SEL_MIN_TENS: begin
                r.minute_tens = t.minute_tens + 3'd1;
                if (r.minute_tens >= C_MTENS_WRAP) r.minute_tens = '0;
            end
            SEL_HOUR_UNITS: begin
                r.hour_units = t.hour_units + 4'd1;
                if (r.hour_units >= C_UNITS_WRAP ||
                    (r.hour_units > C_HUNITS_LATE && t.hour_tens >= C_HTENS_TOP))
                    r.hour_units = '0;
            end
            SEL_HOUR_TENS: begin
                r.hour_tens = t.hour_tens + 2'd1;
                if (r.hour_tens >= C_HTENS_WRAP ||
                    (t.hour_units > C_HUNITS_LATE && r.hour_tens > C_HTENS_EARLY))
                    r.hour_tens = '0;
            end
            default: r = t;
        endcase
        return r;
    endfunction

    // Decrement the selected digit under the hour limits
    function automatic t_time f_decrement(input t_time t, input t_digit_sel sel);
        t_time r;
        r = t;
        case (sel)
            SEL_MIN_UNITS: begin
                r.minute_units = (t.minute_units != '0) ? t.minute_units - 4'd1
                                                        : C_UNITS_TOP;
            end
            SEL_MIN_TENS: begin
                r.minute_tens = (t.minute_tens != '0) ? t.minute_tens - 3'd1
                                                      : C_MTENS_TOP;
            end
            SEL_HOUR_UNITS: begin
                if (t.hour_units != '0)
                    r.hour_units = t.hour_units - 4'd1;
                else
                    r.hour_units = (t.hour_tens > C_HTENS_EARLY) ? C_HUNITS_LATE
                                                                 : C_UNITS_TOP;
            end
            SEL_HOUR_TENS: begin
                if (t.hour_tens != '0)
                    r.hour_tens = t.hour_tens - 2'd1;
                else
                    r.hour_tens = (t.hour_units > C_HUNITS_LATE) ? C_HTENS_EARLY
                                                                 : C_HTENS_TOP;
            end
            default: r = t;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/hhmm_clock_with_digit_set.sv =====
// Top level of the 24-hour HH:MM clock with digit-set buttons.
// A result is registered and shows on the master side in the cycle after its input
// transfer. Throughput: one input item per cycle while the result register is empty
// or draining; time and seconds registers update in the same cycle an item is taken.
// Reset (synchronous, active low): time 00:00, digit select 0, seconds 0,
// minute length 60, no result pending.
`include "assert_macros.svh"

module hhmm_clock_with_digit_set
    import hhmm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] set_mode, [1] field_press, [2] inc_press,
                                   // [3] dec_press, [7:4] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] minute_units, [6:4] minute_tens,
                                   // [10:7] hour_units, [12:11] hour_tens,
                                   // [14:13] selected_digit, [15] blank_selected
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_valid;
    logic [15:0] r_result;
    t_time      r_time;
    t_time      n_time;
    t_digit_sel r_sel;
    t_digit_sel n_sel;
    logic [7:0] r_sec;
    logic [7:0] n_sec;
    logic [7:0] r_spm;
    logic [8:0] sec_next;
    logic       in_xfer;
    logic       set_mode;
    logic       field_press;
    logic       inc_press;
    logic       dec_press;
    logic       cfg_wr;

    assign set_mode    = s_tdata[0];
    assign field_press = s_tdata[1];
    assign inc_press   = s_tdata[2];
    assign dec_press   = s_tdata[3];

    // Take a new item whenever the result register is empty or draining
    assign s_tready = !r_valid || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Configuration access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == C_REG_SPM);
    assign prdata = (paddr[2] == C_REG_SPM) ? {24'd0, r_spm} : 32'd0;

    // Compute next time, select and seconds count for one pass
    assign sec_next = {1'b0, r_sec} + 9'd1;

    always_comb begin
        n_time = r_time;
        n_sel  = r_sel;
        n_sec  = r_sec;
        if (set_mode) begin
            if (field_press) n_sel = t_digit_sel'(r_sel + 2'd1);
            if (inc_press)
                n_time = f_increment(r_time, n_sel);
            else if (dec_press)
                n_time = f_decrement(r_time, n_sel);
        end else begin
            if (sec_next >= {1'b0, r_spm}) begin
                n_sec  = '0;
                n_time = f_advance(r_time);
            end else begin
                n_sec = sec_next[7:0];
            end
        end
    end

    // Hold the minute length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= C_SPM_RESET;
        end else if (cfg_wr) begin
            r_spm <= pwdata[7:0];
        end
    end

    // Advance clock state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_sel  <= SEL_MIN_UNITS;
            r_sec  <= '0;
        end else if (in_xfer) begin
            r_time <= n_time;
            r_sel  <= n_sel;
            r_sec  <= n_sec;
        end
    end

    // Track result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= {set_mode, n_sel, n_time};
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = r_result;

    // Checks
    `ASSERT_SAME(a_htens_range, i_clk, i_rst_n, 1'b1, r_time.hour_tens != C_HTENS_WRAP, "hour tens out of range")
    `ASSERT_SAME(a_late_hours, i_clk, i_rst_n, r_time.hour_tens == C_HTENS_TOP, r_time.hour_units <= C_HUNITS_LATE, "hour beyond 23")
    `ASSERT_NEXT(a_set_holds_sec, i_clk, i_rst_n, in_xfer && set_mode, $stable(r_sec), "seconds moved in set mode")
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_xfer, m_tvalid, "no result after input transfer")

endmodule

// ===== tb/hhmm_clock_with_digit_set_test.sv =====
// Self-checking testbench for the HH:MM clock: predicts every display transfer and compares it
module hhmm_clock_with_digit_set_test
    import hhmm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Input item bits as packed in s_tdata
    localparam logic [3:0] P_RUN   = 4'b0000;
    localparam logic [3:0] P_SET   = 4'b0001;
    localparam logic [3:0] P_FIELD = 4'b0010;
    localparam logic [3:0] P_INC   = 4'b0100;
    localparam logic [3:0] P_DEC   = 4'b1000;

    localparam logic [2:0]  SPM_ADDR   = {C_REG_SPM, 2'b00};
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned HOLD_LEN   = 300;
    localparam int          PHASE_ITEMS = 250;

    // One display transfer, minute units in the lowest bits
    typedef struct packed {
        logic       blank;
        t_digit_sel sel;
        t_time      hhmm;
    } t_display;

    // Tracks the clock state and the displays still owed by the block
    class t_time_checker;
        t_time      hhmm;
        t_digit_sel sel;
        logic [7:0] secs;
        logic [7:0] minute_len;
        t_display   pending_displays[$];
        int         errors;

        function new();
            hhmm       = '0;
            sel        = SEL_MIN_UNITS;
            secs       = '0;
            minute_len = C_SPM_RESET;
            errors     = 0;
        endfunction

        function void set_minute_len(input logic [7:0] value);
            minute_len = value;
        endfunction

        function int waiting();
            return pending_displays.size();
        endfunction

        // Carry one minute through the digits, 23:59 wraps to 00:00
        function void tick_minute();
            if (hhmm.hour_tens == 2 && hhmm.hour_units == 3 && hhmm.minute_tens == 5 &&
                hhmm.minute_units >= 9) begin
                hhmm = '0;
            end else if (hhmm.minute_units < 9) begin
                hhmm.minute_units = hhmm.minute_units + 4'd1;
            end else begin
                hhmm.minute_units = '0;
                if (hhmm.minute_tens < 5) begin
                    hhmm.minute_tens = hhmm.minute_tens + 3'd1;
                end else begin
                    hhmm.minute_tens = '0;
                    if (hhmm.hour_units < 9) begin
                        hhmm.hour_units = hhmm.hour_units + 4'd1;
                    end else begin
                        hhmm.hour_units = '0;
                        hhmm.hour_tens  = (hhmm.hour_tens >= 2) ? 2'd0 : hhmm.hour_tens + 2'd1;
                    end
                end
            end
        endfunction

        // Raise the selected digit, wrapping at its limit
        function void bump_up();
            int v;
            case (sel)
                SEL_MIN_UNITS: begin
                    v = hhmm.minute_units + 1;
                    hhmm.minute_units = (v >= 10) ? 4'd0 : v[3:0];
                end
                SEL_MIN_TENS: begin
                    v = hhmm.minute_tens + 1;
                    hhmm.minute_tens = (v >= 6) ? 3'd0 : v[2:0];
                end
                SEL_HOUR_UNITS: begin
                    v = hhmm.hour_units + 1;
                    if (v >= 10 || (v > 3 && hhmm.hour_tens >= 2)) v = 0;
                    hhmm.hour_units = v[3:0];
                end
                default: begin
                    v = hhmm.hour_tens + 1;
                    if (v >= 3 || (v > 1 && hhmm.hour_units > 3)) v = 0;
                    hhmm.hour_tens = v[1:0];
                end
            endcase
        endfunction

        // Lower the selected digit, zero wraps to the highest legal value
        function void bump_down();
            case (sel)
                SEL_MIN_UNITS: begin
                    hhmm.minute_units = (hhmm.minute_units != 0) ?
                                        hhmm.minute_units - 4'd1 : 4'd9;
                end
                SEL_MIN_TENS: begin
                    hhmm.minute_tens = (hhmm.minute_tens != 0) ?
                                       hhmm.minute_tens - 3'd1 : 3'd5;
                end
                SEL_HOUR_UNITS: begin
                    if (hhmm.hour_units != 0)
                        hhmm.hour_units = hhmm.hour_units - 4'd1;
                    else
                        hhmm.hour_units = (hhmm.hour_tens > 1) ? 4'd3 : 4'd9;
                end
                default: begin
                    if (hhmm.hour_tens != 0)
                        hhmm.hour_tens = hhmm.hour_tens - 2'd1;
                    else
                        hhmm.hour_tens = (hhmm.hour_units > 3) ? 2'd1 : 2'd2;
                end
            endcase
        endfunction

        // Apply one accepted second pass and queue the display it yields
        function void note_press(input logic [3:0] press);
            t_display d;
            if (press[0]) begin
                if (press[1]) sel = t_digit_sel'(sel + 2'd1);
                if (press[2])
                    bump_up();
                else if (press[3])
                    bump_down();
            end else if ({1'b0, secs} + 9'd1 >= {1'b0, minute_len}) begin
                secs = '0;
                tick_minute();
            end else begin
                secs = secs + 8'd1;
            end
            d.blank = press[0];
            d.sel   = sel;
            d.hhmm  = hhmm;
            pending_displays.push_back(d);
        endfunction

        task report(input string what, input int got, input int want);
            $display("ERROR %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        // Compare one display transfer with the oldest one owed
        task check_display(input logic [15:0] data);
            t_display got;
            t_display want;
            got = data;
            if (pending_displays.size() == 0) begin
                report("display with none pending", data, 0);
                return;
            end
            want = pending_displays.pop_front();
            if (got.hhmm.minute_units !== want.hhmm.minute_units)
                report("minute_units", got.hhmm.minute_units, want.hhmm.minute_units);
            if (got.hhmm.minute_tens !== want.hhmm.minute_tens)
                report("minute_tens", got.hhmm.minute_tens, want.hhmm.minute_tens);
            if (got.hhmm.hour_units !== want.hhmm.hour_units)
                report("hour_units", got.hhmm.hour_units, want.hhmm.hour_units);
            if (got.hhmm.hour_tens !== want.hhmm.hour_tens)
                report("hour_tens", got.hhmm.hour_tens, want.hhmm.hour_tens);
            if (got.sel !== want.sel)
                report("selected_digit", got.sel, want.sel);
            if (got.blank !== want.blank)
                report("blank_selected", got.blank, want.blank);
        endtask

        task finish_check();
            if (pending_displays.size() != 0)
                report("displays never delivered", pending_displays.size(), 0);
        endtask
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [0] set_mode, [1] field_press, [2] inc_press,
                                  // [3] dec_press, [7:4] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [3:0] minute_units, [6:4] minute_tens,
                                  // [10:7] hour_units, [12:11] hour_tens,
                                  // [14:13] selected_digit, [15] blank_selected
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    t_time_checker book = new();
    int          tx_idle_pct  = 10;
    int          rx_idle_pct  = 57;
    logic        hold_request = 1'b0;

    hhmm_clock_with_digit_set dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Write the minute length through the configuration port
    task automatic write_minute_len(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SPM_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_minute_len(value);
    endtask

    // Offer one second pass, with a random gap first; valid stays high afterward
    task automatic send_item(input logic [3:0] press);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, press};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        book.note_press(press);
    endtask

    // Drop valid and wait until every owed display has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.waiting() != 0) @(posedge i_clk);
    endtask

    // Run random bursts of set-mode edits and run-mode seconds with random buttons
    task automatic run_phase(input int count, input int run_pct);
        int          left;
        int          burst;
        logic        run_burst;
        logic [31:0] rnd;
        left = count;
        while (left > 0) begin
            run_burst = ($urandom_range(0, 99) < run_pct);
            burst     = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                rnd = $urandom();
                send_item({rnd[2:0], ~run_burst});
                burst--;
                left--;
            end
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, and the display check
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) book.check_display(m_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on total run length
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("hhmm_clock_with_digit_set: mismatch");
        $finish;
    end

    // Main sequence
    initial begin
        logic [7:0] minute_plan [8];
        logic [7:0] len;
        minute_plan = '{8'd255, 8'd0, 8'd200, 8'd3, 8'd1, 8'd2, 8'd60, 8'd5};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-pass minutes so every run pass carries
        write_minute_len(8'd1);
        send_item(P_SET | P_DEC);               // minute units 0 wraps to 9
        send_item(P_SET | P_FIELD | P_DEC);     // minute tens 0 wraps to 5
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_DEC);               // hour tens 0 to 2 with low hour units
        send_item(P_SET | P_FIELD);             // selection wraps back to minute units
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_FIELD | P_DEC);     // hour units 0 to 3 late in the day: 23:59
        send_item(P_RUN);                       // full carry, 23:59 to 00:00
        send_item(P_SET | P_INC | P_DEC);       // increment wins over decrement
        send_item(P_SET | P_FIELD | P_INC);
        send_item(P_SET | P_INC);               // 21:00
        send_item(P_SET | P_DEC);               // 11:00
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_FIELD | P_DEC);     // 10:00
        send_item(P_SET | P_DEC);               // hour units 0 to 9 early in the day
        send_item(P_SET | P_FIELD | P_INC);     // hour tens past 1 with hour units above 3
        send_item(P_SET | P_DEC);               // hour tens 0 to 1 with hour units above 3
        send_item(P_SET | P_INC);
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_FIELD);
        send_item(P_SET | P_FIELD | P_INC);     // hour units 9 wraps to 0
        send_item(P_FIELD | P_INC | P_DEC);     // buttons ignored in run mode
        send_item(P_RUN);
        drain();

        // Random phases across minute lengths and idle patterns
        for (int phase = 0; phase < 8; phase++) begin
            if (phase < 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 57;
            end else if (phase < 6) begin
                tx_idle_pct = 57;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            len = (phase == 7) ? 8'($urandom_range(1, 9)) : minute_plan[phase];
            write_minute_len(len);
            if (phase == 1) hold_request = 1'b1;
            run_phase(PHASE_ITEMS, (len >= 60) ? 85 : 50);
            drain();
        end

        repeat (4) @(posedge i_clk);
        book.finish_check();
        if (book.errors == 0)
            $display("hhmm_clock_with_digit_set: match");
        else
            $display("hhmm_clock_with_digit_set: mismatch");
        $finish;
    end

endmodule
